### design/pfat_pkg.sv
// Shared types and constants for the page frame allocator table.
package pfat_pkg;

  localparam int NUM_FRAMES   = 8;
  localparam int PROCESS_BITS = 8;
  localparam int PAGE_BITS    = 16;
  localparam int FRAME_BITS   = 3;
  localparam int IDX_BITS     = 3;
  localparam int COUNT_BITS   = 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic                    op;
    logic [PROCESS_BITS-1:0] process_id;
    logic [PAGE_BITS-1:0]    page_number;
  } cmd_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [FRAME_BITS-1:0] frame_number;
  } result_t;

  typedef struct packed {
    logic [PROCESS_BITS-1:0] process_id;
    logic [PAGE_BITS-1:0]    page_number;
    logic [FRAME_BITS-1:0]   frame;
  } entry_t;

  typedef struct packed {
    logic                  set_en;
    logic [FRAME_BITS-1:0] set_idx;
    logic                  clr_en;
    logic [FRAME_BITS-1:0] clr_idx;
  } map_ctl_t;

  typedef struct packed {
    logic                  any_free;
    logic [FRAME_BITS-1:0] free_idx;
  } map_stat_t;

endpackage

### design/page_frame_allocator_table.sv
// Top level: first-free page frame allocator with a (process, page) -> frame table.
//
// Usage:
//   Command channel: drive cmd and raise start; the beat is taken at a clock
//   edge where start is high and busy is low. cmd.op selects allocate or free.
//   Result channel: result_valid is high for exactly one cycle with the
//   status and frame in result. There is no back-pressure; the receiver must
//   take the beat in that cycle.
// Flow:
//   Allocate: result in the next cycle; busy stays low, so another
//   command may follow at once.
//   Free: busy is raised while the table memory is scanned one entry per
//   cycle through its single registered read port, then S_MOVE moves the
//   last entry into the freed slot when the hit was not the tail. A miss
//   ends on the last entry; a free on an empty table does not raise busy.
// State: one RAM holds the table entries; the used-frame bitmap and the entry
//   count are flip-flops. Only one command is in flight at a time, so reads
//   and writes of the same entry never overlap and no forwarding is needed.
// Reset: rst (synchronous) empties the table and frees all frames; the RAM
//   contents are not cleared, since only entries below the count are read.
module page_frame_allocator_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pfat_pkg::cmd_t    cmd,
  output logic              result_valid,
  output pfat_pkg::result_t result
);
  import pfat_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_MOVE = 3'b100
  } state_t;

  state_t                  state, state_next;
  cmd_t                    cmd_q, cmd_q_next;
  logic [IDX_BITS-1:0]     idx, idx_next;
  logic [COUNT_BITS-1:0]   count, count_next;
  logic [FRAME_BITS-1:0]   frame_q, frame_q_next;
  result_t                 result_next;
  logic                    result_valid_next;

  // table RAM ports
  logic                    wr_en;
  logic [IDX_BITS-1:0]     wr_addr;
  entry_t                  wr_data;
  logic [IDX_BITS-1:0]     rd_addr;
  entry_t                  rd_data;

  map_ctl_t                map_ctl;
  map_stat_t               map_stat;

  logic [COUNT_BITS-1:0]   count_dec;
  logic [IDX_BITS-1:0]     last_idx;
  logic                    hit_last;
  logic                    match;

  pfat_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_FRAMES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pfat_frame_map u_map (
    .clk  (clk),
    .rst  (rst),
    .ctl  (map_ctl),
    .stat (map_stat)
  );

  assign busy      = (state != S_IDLE);
  assign count_dec = count - 1'b1;
  assign last_idx  = count_dec[IDX_BITS-1:0];
  assign hit_last  = (idx == last_idx);
  // entry under test is in rd_data during S_SCAN
  assign match     = (rd_data.process_id == cmd_q.process_id) &&
                     (rd_data.page_number == cmd_q.page_number);

  always_comb begin
    state_next        = state;
    cmd_q_next        = cmd_q;
    idx_next          = idx;
    count_next        = count;
    frame_q_next      = frame_q;
    result_next       = result;
    result_valid_next = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = count[IDX_BITS-1:0];
    wr_data           = rd_data;
    rd_addr           = idx;
    map_ctl           = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_q_next = cmd;
          if (cmd.op == OP_ALLOC) begin
            result_valid_next = 1'b1;
            if (map_stat.any_free && (count < COUNT_BITS'(NUM_FRAMES))) begin
              // append entry at the tail, mark frame used
              wr_en               = 1'b1;
              wr_addr             = count[IDX_BITS-1:0];
              wr_data.process_id  = cmd.process_id;
              wr_data.page_number = cmd.page_number;
              wr_data.frame       = map_stat.free_idx;
              map_ctl.set_en      = 1'b1;
              map_ctl.set_idx     = map_stat.free_idx;
              count_next          = count + 1'b1;
              result_next.status       = ST_ALLOCATED;
              result_next.frame_number = map_stat.free_idx;
            end else begin
              result_next.status       = ST_FULL;
              result_next.frame_number = '0;
            end
          end else if (count == '0) begin
            result_valid_next        = 1'b1;
            result_next.status       = ST_NOT_FOUND;
            result_next.frame_number = '0;
          end else begin
            // start scan at entry 0
            rd_addr    = '0;
            idx_next   = '0;
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (match) begin
          map_ctl.clr_en = 1'b1;
          map_ctl.clr_idx = rd_data.frame;
          frame_q_next   = rd_data.frame;
          if (hit_last) begin
            // hit on the tail entry: nothing to move
            count_next               = count_dec;
            result_valid_next        = 1'b1;
            result_next.status       = ST_FREED;
            result_next.frame_number = rd_data.frame;
            state_next               = S_IDLE;
          end else begin
            rd_addr    = last_idx;
            state_next = S_MOVE;
          end
        end else if (hit_last) begin
          result_valid_next        = 1'b1;
          result_next.status       = ST_NOT_FOUND;
          result_next.frame_number = '0;
          state_next               = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
          rd_addr  = idx + 1'b1;
        end
      end

      S_MOVE: begin
        // tail entry now in rd_data; copy into the vacated slot
        wr_en                    = 1'b1;
        wr_addr                  = idx;
        wr_data                  = rd_data;
        count_next               = count_dec;
        result_valid_next        = 1'b1;
        result_next.status       = ST_FREED;
        result_next.frame_number = frame_q;
        state_next               = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q   <= cmd_q_next;
    idx     <= idx_next;
    frame_q <= frame_q_next;
    result  <= result_next;
  end

endmodule

### design/pfat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/pfat_frame_map.sv
// Used-frame bitmap with a lowest-free-frame encoder.
module pfat_frame_map (
  input  logic                 clk,
  input  logic                 rst,
  input  pfat_pkg::map_ctl_t   ctl,
  output pfat_pkg::map_stat_t  stat
);
  import pfat_pkg::*;

  logic [NUM_FRAMES-1:0] used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (ctl.set_en) begin
        used[ctl.set_idx] <= 1'b1;
      end
      if (ctl.clr_en) begin
        used[ctl.clr_idx] <= 1'b0;
      end
    end
  end

  // priority toward frame 0
  always_comb begin
    stat = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        stat.any_free = 1'b1;
        stat.free_idx = FRAME_BITS'(i);
      end
    end
  end

endmodule

### design/pfat_checker.sv
// Port-level checker for the page frame allocator table, with its bind.
module pfat_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input pfat_pkg::cmd_t    cmd,
  input logic              result_valid,
  input pfat_pkg::result_t result
);
  import pfat_pkg::*;

  // reset leaves the block idle with no result beat
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !result_valid))
    else $error("not idle after reset");

  // allocate answers in the next cycle
  a_alloc_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.op == OP_ALLOC) |=>
      (result_valid && (result.status == ST_ALLOCATED || result.status == ST_FULL)))
    else $error("allocate result missing or wrong status");

  // busy is only raised by an accepted free command
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && cmd.op == OP_FREE))
    else $error("busy raised without a free command");

  // full and not-found beats carry frame zero
  a_zero_frame: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == ST_FULL || result.status == ST_NOT_FOUND))
      |-> (result.frame_number == '0))
    else $error("nonzero frame on full or not-found result");

  // every result beat follows a command or ongoing work
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(busy) || $past(start)))
    else $error("result beat with no command");

endmodule

bind page_frame_allocator_table pfat_checker u_checker (.*);
